// ----- hw/rtl/gha_pkg.sv -----
// shared types, codes and mixing constants of the generational handle allocator
package gha_pkg;

  // request codes
  localparam logic [1:0] REQ_CREATE  = 2'd0;
  localparam logic [1:0] REQ_DESTROY = 2'd1;
  localparam logic [1:0] REQ_CHECK   = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_CAPACITY = 2'd1;
  localparam logic [1:0] STAT_INVALID  = 2'd2;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_WORLD_ID     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SOURCE_ID    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_INSTANCE_KEY = 2'd2;
  localparam logic [63:0] WORLD_ID_RESET = 64'd1;

  // splitmix64 finalizer constants
  localparam logic [63:0] MIX_M1     = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_M2     = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] ZERO_SUBST = 64'h9E37_79B9_7F4A_7C15;
  localparam int unsigned MIX_SH0 = 30;
  localparam int unsigned MIX_SH1 = 27;
  localparam int unsigned MIX_SH2 = 31;

  localparam logic [31:0] GEN_MAX = 32'hFFFF_FFFF;

  // partial products of one 64x64 low-half multiply
  localparam logic [1:0] MUL_STEP_LL = 2'd0;
  localparam logic [1:0] MUL_STEP_LH = 2'd1;
  localparam logic [1:0] MUL_STEP_HL = 2'd2;

  // multiplier constant select
  localparam logic MUL_SEL_M1 = 1'b0;
  localparam logic MUL_SEL_M2 = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] handle_world;
    logic [63:0] handle_source;
    logic [31:0] handle_index;
    logic [31:0] handle_generation;
    logic [63:0] handle_token;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_live;
    logic [9:0]  new_index;
    logic [31:0] new_generation;
    logic [63:0] new_token;
    logic [10:0] live_total;
  } rsp_t;

  // one slot table entry
  typedef struct packed {
    logic        retired;
    logic        alive;
    logic [31:0] gen;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_POP,
    ST_SLOT,
    ST_MIX,
    ST_MUL1,
    ST_XS27,
    ST_MUL2,
    ST_XS31,
    ST_FIN
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       pop;
    logic       take_pop;
    logic       take_slot;
    logic       fresh;
    logic       hidx;
    logic       cap;
    logic       mix;
    logic       mul;
    logic       mul_sel;
    logic [1:0] mul_step;
    logic       xs27;
    logic       xs31;
    logic       fin;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       stack_empty;
    logic       table_full;
    logic       out_busy;
  } sts_t;

endpackage

// ----- hw/rtl/gha_ctrl.sv -----
// sequencing state machine of the generational handle allocator
module gha_ctrl import gha_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic [1:0] step_q, step_d;

  // state and step registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= MUL_STEP_LL;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // partial product counter
  always_comb begin
    step_d = MUL_STEP_LL;
    if ((state_q == ST_MUL1 || state_q == ST_MUL2) && step_q != MUL_STEP_HL) begin
      step_d = step_q + 2'd1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        case (sts_i.req_type)
          REQ_CREATE: begin
            if (!sts_i.stack_empty) state_d = ST_POP;
            else if (!sts_i.table_full) state_d = ST_MIX;
            else state_d = ST_FIN;
          end
          REQ_DESTROY, REQ_CHECK: state_d = ST_MIX;
          default: state_d = ST_FIN;
        endcase
      end
      ST_POP:  state_d = ST_SLOT;
      ST_SLOT: state_d = ST_MIX;
      ST_MIX:  state_d = ST_MUL1;
      ST_MUL1: begin
        if (step_q == MUL_STEP_HL) state_d = ST_XS27;
      end
      ST_XS27: state_d = ST_MUL2;
      ST_MUL2: begin
        if (step_q == MUL_STEP_HL) state_d = ST_XS31;
      end
      ST_XS31: state_d = ST_FIN;
      ST_FIN: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      ST_SETUP: begin
        case (sts_i.req_type)
          REQ_CREATE: begin
            if (!sts_i.stack_empty) cmd_o.pop = 1'b1;
            else if (!sts_i.table_full) cmd_o.fresh = 1'b1;
            else cmd_o.cap = 1'b1;
          end
          REQ_DESTROY, REQ_CHECK: cmd_o.hidx = 1'b1;
          default: ;
        endcase
      end
      ST_POP:  cmd_o.take_pop = 1'b1;
      ST_SLOT: cmd_o.take_slot = 1'b1;
      ST_MIX:  cmd_o.mix = 1'b1;
      ST_MUL1: begin
        cmd_o.mul      = 1'b1;
        cmd_o.mul_sel  = MUL_SEL_M1;
        cmd_o.mul_step = step_q;
      end
      ST_XS27: cmd_o.xs27 = 1'b1;
      ST_MUL2: begin
        cmd_o.mul      = 1'b1;
        cmd_o.mul_sel  = MUL_SEL_M2;
        cmd_o.mul_step = step_q;
      end
      ST_XS31: cmd_o.xs31 = 1'b1;
      ST_FIN:  cmd_o.fin = !sts_i.out_busy;
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/gha_dp.sv -----
// slot table, free stack, token mixer and result register
module gha_dp import gha_pkg::*; #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  req_t               in_req_i,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output rsp_t               out_rsp_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  // memories
  slot_t         slot_mem [SLOTS];
  logic [IW-1:0] stk_mem  [SLOTS];

  logic [63:0] world_q, source_q, key_q;
  req_t        req_q;
  logic [31:0] idx_q, gen_q;
  logic [63:0] v_q, v_d, acc_q, acc_d;
  logic        cap_q;
  logic [CW-1:0] used_q, top_q, live_q, live_d;
  logic [IW-1:0] stk_rd_q;
  slot_t         slot_rd_q;
  logic          out_valid_q;
  rsp_t          rsp_q, rsp_d;

  logic          slot_re, slot_we, stk_we;
  logic [IW-1:0] slot_raddr, stk_raddr;
  slot_t         slot_wdata;
  logic [63:0]   x, mul_k, tok;
  logic [31:0]   op_a, op_b;
  logic [63:0]   prod;
  logic          range_ok, hdl_ok, retire;
  logic [31:0]   live32;

  // status to controller
  assign sts_o.req_type    = req_q.req_type;
  assign sts_o.stack_empty = (top_q == '0);
  assign sts_o.table_full  = (used_q == CW'(SLOTS));
  assign sts_o.out_busy    = out_valid_q && !out_ready_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      world_q  <= WORLD_ID_RESET;
      source_q <= '0;
      key_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WORLD_ID:     world_q  <= cfg_data_i;
        CFG_SOURCE_ID:    source_q <= cfg_data_i;
        CFG_INSTANCE_KEY: key_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // memory addressing
  assign stk_raddr  = IW'(top_q - CW'(1));
  assign slot_re    = cmd_i.take_pop | cmd_i.hidx;
  assign slot_raddr = cmd_i.take_pop ? stk_rd_q : IW'(req_q.handle_index);

  // slot table; a read at or above the fill count is rejected by the range check
  always_ff @(posedge clk_i) begin
    if (slot_re) slot_rd_q <= slot_mem[slot_raddr];
    if (slot_we) slot_mem[IW'(idx_q)] <= slot_wdata;
  end

  // free stack
  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) stk_rd_q <= stk_mem[stk_raddr];
    if (stk_we) stk_mem[IW'(top_q)] <= IW'(idx_q);
  end

  // request, index and generation latches
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_req_i;
    if (cmd_i.fresh) begin
      idx_q <= 32'(used_q);
      gen_q <= '0;
    end else if (cmd_i.hidx) begin
      idx_q <= req_q.handle_index;
      gen_q <= req_q.handle_generation;
    end else if (cmd_i.take_pop) begin
      idx_q <= 32'(stk_rd_q);
    end else if (cmd_i.take_slot) begin
      gen_q <= slot_rd_q.gen;
    end
  end

  // token mixer: xorshift steps
  assign x = world_q ^ {idx_q, gen_q} ^ key_q ^ source_q;
  always_comb begin
    v_d = v_q;
    if (cmd_i.mix) v_d = x ^ (x >> MIX_SH0);
    else if (cmd_i.xs27) v_d = acc_q ^ (acc_q >> MIX_SH1);
    else if (cmd_i.xs31) v_d = acc_q ^ (acc_q >> MIX_SH2);
  end

  // shared 32x32 multiplier, one partial product a cycle
  assign mul_k = (cmd_i.mul_sel == MUL_SEL_M2) ? MIX_M2 : MIX_M1;
  always_comb begin
    case (cmd_i.mul_step)
      MUL_STEP_LH: begin
        op_a = v_q[31:0];
        op_b = mul_k[63:32];
      end
      MUL_STEP_HL: begin
        op_a = v_q[63:32];
        op_b = mul_k[31:0];
      end
      default: begin
        op_a = v_q[31:0];
        op_b = mul_k[31:0];
      end
    endcase
  end
  assign prod = op_a * op_b;
  assign acc_d = (cmd_i.mul_step == MUL_STEP_LL) ? prod :
                 {acc_q[63:32] + prod[31:0], acc_q[31:0]};

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    if (cmd_i.mul) acc_q <= acc_d;
  end

  // handle validation
  assign tok      = (v_q == '0) ? ZERO_SUBST : v_q;
  assign range_ok = req_q.handle_index < 32'(used_q);
  assign hdl_ok   = (req_q.handle_source == source_q) && (req_q.handle_world == world_q)
                 && range_ok && slot_rd_q.alive && !slot_rd_q.retired
                 && (slot_rd_q.gen == req_q.handle_generation)
                 && (req_q.handle_token == tok);
  assign retire   = (gen_q == GEN_MAX);

  // commit and result
  always_comb begin
    slot_we    = 1'b0;
    stk_we     = 1'b0;
    slot_wdata = '0;
    live_d     = live_q;
    rsp_d      = '0;
    case (req_q.req_type)
      REQ_CREATE: begin
        if (cap_q) begin
          rsp_d.status = STAT_CAPACITY;
        end else begin
          slot_we              = cmd_i.fin;
          slot_wdata.alive     = 1'b1;
          slot_wdata.gen       = gen_q;
          live_d               = live_q + CW'(1);
          rsp_d.is_live        = 1'b1;
          rsp_d.new_index      = idx_q[9:0];
          rsp_d.new_generation = gen_q;
          rsp_d.new_token      = tok;
        end
      end
      REQ_DESTROY: begin
        if (hdl_ok) begin
          slot_we            = cmd_i.fin;
          slot_wdata.retired = retire;
          slot_wdata.gen     = retire ? gen_q : gen_q + 32'd1;
          live_d             = live_q - CW'(1);
          stk_we             = cmd_i.fin && !retire && (top_q < CW'(SLOTS));
        end else begin
          rsp_d.status = STAT_INVALID;
        end
      end
      REQ_CHECK: rsp_d.is_live = hdl_ok;
      default: ;
    endcase
    live32           = 32'(live_d);
    rsp_d.live_total = live32[10:0];
  end

  // counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      top_q       <= '0;
      live_q      <= '0;
      cap_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) cap_q <= 1'b0;
      else if (cmd_i.cap) cap_q <= 1'b1;
      if (cmd_i.fresh) used_q <= used_q + CW'(1);
      if (cmd_i.pop) top_q <= top_q - CW'(1);
      else if (stk_we) top_q <= top_q + CW'(1);
      if (cmd_i.fin) begin
        live_q      <= live_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ----- hw/rtl/generational_handle_allocator.sv -----
// Generational handle allocator, top level.
// Requests (create, destroy, check) enter on in_valid_i/in_ready_o with one
// req_t payload; every request gives exactly one rsp_t on out_valid_o/
// out_ready_i. Configuration writes (world id, source identity, instance key)
// use cfg_valid_i/cfg_ready_o with an index and 64-bit data, always ready;
// the user must issue them while no request is in flight, which the block does not enforce.
// One request is processed at a time. Most of the work lies in the token
// mix: two 64-bit multiplies each run as three partial products through
// one shared 32x32 multiplier, and a stack pop adds two registered memory
// reads. in_ready_o rises at the edge that registers the result, so the
// next request can be taken while the result still waits.
// If the receiver stalls, the next request holds in its last step until
// the result register is free.
// Reset clears the counters and flags and loads the configuration
// defaults; slot entries past the fill count read as never used, so no
// clearing pass is needed.
module generational_handle_allocator import gha_pkg::*; #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  req_t               in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rsp_t               out_rsp_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // configuration writes never stall
  assign cfg_ready_o = 1'b1;

  // controller
  gha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  gha_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_req_i    (in_req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
